@@ hw/rtl/min_slimness_spanning_tree_macros.svh @@
// ----------------------------------------------------------------------------
// Slimmest spanning tree - assertion macros
// Shared property wrappers for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MIN_SLIMNESS_SPANNING_TREE_MACROS_SVH
`define MIN_SLIMNESS_SPANNING_TREE_MACROS_SVH

// same-cycle implication
`define MSST_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MSST_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/msst_pkg.sv @@
// ----------------------------------------------------------------------------
// Slimmest spanning tree - package
// Sizes, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package msst_pkg;

   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 256;
   localparam int NODE_W    = 6;   // node index
   localparam int NCNT_W    = 7;   // node count / set size
   localparam int EDGE_AW   = 8;   // edge store address
   localparam int ECNT_W    = 9;   // edge count
   localparam int WEIGHT_W  = 31;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RK_RDI,
      ST_RK_KEY,
      ST_RK_RDJ,
      ST_RK_CMP,
      ST_SV_OUTER,
      ST_SV_CLR,
      ST_SV_ORD,
      ST_SV_EDGE,
      ST_SV_GOT,
      ST_SV_FRD,
      ST_SV_FCHK,
      ST_SV_SZA,
      ST_SV_SZB,
      ST_SV_MERGE,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_START,
      CMD_TRIVIAL,
      CMD_FINISH,
      CMD_RK_RDI,
      CMD_RK_KEY,
      CMD_RK_RDJ,
      CMD_RK_CMP,
      CMD_RK_PUT,
      CMD_SV_INIT,
      CMD_SV_OUTER,
      CMD_SV_CLR,
      CMD_SV_ORD,
      CMD_SV_EDGE,
      CMD_SV_GOT,
      CMD_SV_FRD,
      CMD_SV_FCHK,
      CMD_SV_SZA,
      CMD_SV_SZB,
      CMD_SV_MERGE,
      CMD_SV_NEXTJ,
      CMD_SV_NEXTI
   } cmd_type;

   typedef struct packed {
      logic n_trivial;
      logic i_end;
      logic j_end;
      logic outer_end;
      logic clr_last;
      logic jc_end;
      logic root;
      logic phase;
      logic same_root;
      logic last_merge;
   } status_type;

endpackage

@@ hw/rtl/min_slimness_spanning_tree.sv @@
// ----------------------------------------------------------------------------
// Slimmest spanning tree - top level
// Loads weighted edges, then returns the smallest max-minus-min weight of
// any spanning tree over the configured nodes.
// ----------------------------------------------------------------------------
// Edge loads are taken while idle and the next transfer may follow at once. A
// finish runs a rank sort over the E stored edges (one edge-store read per
// comparison), then one Kruskal pass per in-range start edge: the union-find
// is cleared over the N nodes, then each visited edge is read and both ends
// are followed up their parent chains, one parent-memory read per hop; the
// parent and size memories have one read port each. Input stalls for the whole
// finish; loads are still taken while a result waits on rsp.
module min_slimness_spanning_tree (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // end_a[5:0], end_b[11:6], weight[42:12], zero pad
   input  logic        req_tuser,  // op: 0 load edge, 1 finish
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // slimness[30:0], zero pad
   output logic        rsp_tuser,  // found
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata   // node_count
);
   import msst_pkg::*;

`include "min_slimness_spanning_tree_macros.svh"

   cmd_type              cmd;
   status_type           status;
   logic                 busy;
   logic [WEIGHT_W-1:0]  slimness;

   msst_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status),
      .busy       (busy)
   );

   msst_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .in_end_a     (req_tdata[5:0]),
      .in_end_b     (req_tdata[11:6]),
      .in_weight    (req_tdata[42:12]),
      .out_found    (rsp_tuser),
      .out_slimness (slimness)
   );

   assign rsp_tdata = {1'b0, slimness};

   `MSST_ASSERT_IMP(a_not_found_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == 32'd0, "slimness nonzero without a tree")
   `MSST_ASSERT_NXT(a_finish_holds, req_tvalid && req_tready && req_tuser, busy || rsp_tvalid, "finish transfer left block idle")
   `MSST_ASSERT_NXT(a_rsp_single, rsp_tvalid && rsp_tready, !rsp_tvalid, "result repeated")

endmodule

@@ hw/rtl/msst_datapath.sv @@
// ----------------------------------------------------------------------------
// Slimmest spanning tree - datapath
// Edge stores, rank sort, union-find memories and result register.
// ----------------------------------------------------------------------------
module msst_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  msst_pkg::cmd_type                  cmd,
   output msst_pkg::status_type               status,
   input  logic                               csr_we,
   input  logic [msst_pkg::NCNT_W-1:0]        csr_wdata,
   input  logic [msst_pkg::NODE_W-1:0]        in_end_a,
   input  logic [msst_pkg::NODE_W-1:0]        in_end_b,
   input  logic [msst_pkg::WEIGHT_W-1:0]      in_weight,
   output logic                               out_found,
   output logic [msst_pkg::WEIGHT_W-1:0]      out_slimness
);
   import msst_pkg::*;

   // edge stores, sorted order and union-find memories
   logic signed [WEIGHT_W-1:0] ew_mem [MAX_EDGES];
   logic [NODE_W-1:0]          ea_mem [MAX_EDGES];
   logic [NODE_W-1:0]          eb_mem [MAX_EDGES];
   logic [EDGE_AW-1:0]         ord_mem [MAX_EDGES];
   logic [NODE_W-1:0]          par_mem [MAX_NODES];
   logic [NCNT_W-1:0]          siz_mem [MAX_NODES];

   logic signed [WEIGHT_W-1:0] rd_w_ff;
   logic [NODE_W-1:0]          rd_a_ff, rd_b_ff;
   logic [EDGE_AW-1:0]         rd_ord_ff;
   logic [NODE_W-1:0]          rd_par_ff;
   logic [NCNT_W-1:0]          rd_siz_ff;

   logic [NCNT_W-1:0]          node_count_ff;
   logic [ECNT_W-1:0]          edge_total_ff, edge_total_in;
   logic [NCNT_W-1:0]          n_ff, n_in;
   logic [ECNT_W-1:0]          i_ff, i_in, j_ff, j_in, cnt_ff, cnt_in;
   logic [EDGE_AW-1:0]         rank_ff, rank_in;
   logic signed [WEIGHT_W-1:0] key_ff, key_in, base_ff, base_in, cur_ff, cur_in;
   logic                       key_ok_ff, key_ok_in;
   logic [NODE_W-1:0]          k_ff, k_in, x_ff, x_in, eb_ff, eb_in, ra_ff, ra_in;
   logic [NODE_W-1:0]          rb_ff, rb_in;
   logic                       phase_ff, phase_in;
   logic [NCNT_W-1:0]          comp_ff, comp_in, sa_ff, sa_in;
   logic [WEIGHT_W-1:0]        best_ff, best_in;
   logic                       best_valid_ff, best_valid_in;
   logic                       found_ff, found_in;
   logic [WEIGHT_W-1:0]        slim_ff, slim_in;

   logic [EDGE_AW-1:0]         e_addr;
   logic [NODE_W-1:0]          p_addr, s_addr, p_wa, s_wa, p_wd;
   logic [NCNT_W-1:0]          s_wd;
   logic                       p_we, s_we;
   logic [NCNT_W:0]            size_sum;
   logic signed [WEIGHT_W:0]   span_full;
   logic [WEIGHT_W-1:0]        span;
   logic                       j_in_range, j_before;

   assign size_sum  = {1'b0, sa_ff} + {1'b0, rd_siz_ff};
   assign span_full = {cur_ff[WEIGHT_W-1], cur_ff} - {base_ff[WEIGHT_W-1], base_ff};
   assign span      = span_full[WEIGHT_W-1:0];
   assign j_in_range = ({1'b0, rd_a_ff} < n_ff) && ({1'b0, rd_b_ff} < n_ff);
   assign j_before   = (rd_w_ff < key_ff) || ((rd_w_ff == key_ff) && (j_ff < i_ff));

   always_comb begin
      status.n_trivial  = (node_count_ff <= NCNT_W'(1));
      status.i_end      = (i_ff == edge_total_ff);
      status.j_end      = (j_ff == edge_total_ff);
      status.outer_end  = (i_ff == cnt_ff);
      status.clr_last   = ({1'b0, k_ff} == n_ff - NCNT_W'(1));
      status.jc_end     = (j_ff == cnt_ff);
      status.root       = (rd_par_ff == x_ff);
      status.phase      = phase_ff;
      status.same_root  = (ra_ff == rb_ff);
      status.last_merge = (comp_ff == NCNT_W'(2));
   end

   always_comb begin
      edge_total_in = edge_total_ff;
      n_in = n_ff; i_in = i_ff; j_in = j_ff; cnt_in = cnt_ff; rank_in = rank_ff;
      key_in = key_ff; key_ok_in = key_ok_ff; base_in = base_ff; cur_in = cur_ff;
      k_in = k_ff; x_in = x_ff; eb_in = eb_ff; ra_in = ra_ff; rb_in = rb_ff;
      phase_in = phase_ff; comp_in = comp_ff; sa_in = sa_ff;
      best_in = best_ff; best_valid_in = best_valid_ff;
      found_in = found_ff; slim_in = slim_ff;
      e_addr = i_ff[EDGE_AW-1:0];
      p_addr = x_ff; s_addr = ra_ff;
      p_we = 1'b0; p_wa = k_ff; p_wd = k_ff;
      s_we = 1'b0; s_wa = k_ff; s_wd = NCNT_W'(1);
      case (cmd)
         CMD_LOAD: begin
            if (!edge_total_ff[ECNT_W-1]) edge_total_in = edge_total_ff + ECNT_W'(1);
         end
         CMD_START: begin
            n_in = (node_count_ff > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : node_count_ff;
            i_in = '0;
            cnt_in = '0;
            best_in = '1;
            best_valid_in = 1'b0;
         end
         CMD_TRIVIAL: begin
            best_in = '0;
            best_valid_in = 1'b1;
         end
         CMD_FINISH: begin
            found_in = best_valid_ff;
            slim_in = best_valid_ff ? best_ff : '0;
            edge_total_in = '0;
         end
         CMD_RK_RDI: e_addr = i_ff[EDGE_AW-1:0];
         CMD_RK_KEY: begin
            key_in = rd_w_ff;
            key_ok_in = j_in_range;
            j_in = '0;
            rank_in = '0;
         end
         CMD_RK_RDJ: e_addr = j_ff[EDGE_AW-1:0];
         CMD_RK_CMP: begin
            if (j_in_range && j_before) rank_in = rank_ff + EDGE_AW'(1);
            j_in = j_ff + ECNT_W'(1);
         end
         CMD_RK_PUT: begin
            if (key_ok_ff) cnt_in = cnt_ff + ECNT_W'(1);
            i_in = i_ff + ECNT_W'(1);
         end
         CMD_SV_INIT: i_in = '0;
         CMD_SV_OUTER: begin
            k_in = '0;
            comp_in = n_ff;
            j_in = i_ff;
         end
         CMD_SV_CLR: begin
            p_we = 1'b1;
            s_we = 1'b1;
            k_in = k_ff + NODE_W'(1);
         end
         CMD_SV_EDGE: e_addr = rd_ord_ff;
         CMD_SV_GOT: begin
            cur_in = rd_w_ff;
            if (j_ff == i_ff) base_in = rd_w_ff;
            x_in = rd_a_ff;
            eb_in = rd_b_ff;
            phase_in = 1'b0;
         end
         CMD_SV_FRD: p_addr = x_ff;
         CMD_SV_FCHK: begin
            if (rd_par_ff == x_ff) begin
               if (!phase_ff) begin
                  ra_in = x_ff;
                  x_in = eb_ff;
                  phase_in = 1'b1;
               end else begin
                  rb_in = x_ff;
               end
            end else begin
               x_in = rd_par_ff;
            end
         end
         CMD_SV_SZA: s_addr = ra_ff;
         CMD_SV_SZB: begin
            sa_in = rd_siz_ff;
            s_addr = rb_ff;
         end
         CMD_SV_MERGE: begin
            p_we = 1'b1;
            s_we = 1'b1;
            s_wd = size_sum[NCNT_W-1:0];
            if (sa_ff < rd_siz_ff) begin
               p_wa = ra_ff; p_wd = rb_ff; s_wa = rb_ff;
            end else begin
               p_wa = rb_ff; p_wd = ra_ff; s_wa = ra_ff;
            end
            comp_in = comp_ff - NCNT_W'(1);
            if (comp_ff == NCNT_W'(2)) begin
               if (!best_valid_ff || span < best_ff) begin
                  best_in = span;
                  best_valid_in = 1'b1;
               end
               i_in = i_ff + ECNT_W'(1);
            end else begin
               j_in = j_ff + ECNT_W'(1);
            end
         end
         CMD_SV_NEXTJ: j_in = j_ff + ECNT_W'(1);
         CMD_SV_NEXTI: i_in = i_ff + ECNT_W'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD && !edge_total_ff[ECNT_W-1]) begin
         ew_mem[edge_total_ff[EDGE_AW-1:0]] <= in_weight;
         ea_mem[edge_total_ff[EDGE_AW-1:0]] <= in_end_a;
         eb_mem[edge_total_ff[EDGE_AW-1:0]] <= in_end_b;
      end
      rd_w_ff <= ew_mem[e_addr];
      rd_a_ff <= ea_mem[e_addr];
      rd_b_ff <= eb_mem[e_addr];
   end

   // sorted position of edge i is its rank among the in-range edges
   always_ff @(posedge clock) begin
      if (cmd == CMD_RK_PUT && key_ok_ff) ord_mem[rank_ff] <= i_ff[EDGE_AW-1:0];
      rd_ord_ff <= ord_mem[j_ff[EDGE_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (p_we) par_mem[p_wa] <= p_wd;
      rd_par_ff <= par_mem[p_addr];
   end

   always_ff @(posedge clock) begin
      if (s_we) siz_mem[s_wa] <= s_wd;
      rd_siz_ff <= siz_mem[s_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NCNT_W'(1);
         edge_total_ff <= '0;
         best_valid_ff <= 1'b0;
         best_ff       <= '1;
      end else begin
         if (csr_we) node_count_ff <= csr_wdata;
         edge_total_ff <= edge_total_in;
         best_valid_ff <= best_valid_in;
         best_ff       <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; i_ff <= i_in; j_ff <= j_in; cnt_ff <= cnt_in; rank_ff <= rank_in;
      key_ff <= key_in; key_ok_ff <= key_ok_in; base_ff <= base_in; cur_ff <= cur_in;
      k_ff <= k_in; x_ff <= x_in; eb_ff <= eb_in; ra_ff <= ra_in; rb_ff <= rb_in;
      phase_ff <= phase_in; comp_ff <= comp_in; sa_ff <= sa_in;
      found_ff <= found_in; slim_ff <= slim_in;
   end

   assign out_found    = found_ff;
   assign out_slimness = slim_ff;

endmodule

@@ hw/rtl/msst_controller.sv @@
// ----------------------------------------------------------------------------
// Slimmest spanning tree - controller
// Sequences load, rank sort and the Kruskal passes; owns the handshakes.
// ----------------------------------------------------------------------------
module msst_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_op,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output msst_pkg::cmd_type    cmd,
   input  msst_pkg::status_type status,
   output logic                 busy
);
   import msst_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = CMD_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      // loads may go on while a result waits; a finish may not
      req_tready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || !req_op);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (!req_op) begin
                  cmd = CMD_LOAD;
               end else if (status.n_trivial) begin
                  cmd = CMD_TRIVIAL;
                  state_in = ST_DONE;
               end else begin
                  cmd = CMD_START;
                  state_in = ST_RK_RDI;
               end
            end
         end
         ST_RK_RDI: begin
            if (status.i_end) begin
               cmd = CMD_SV_INIT;
               state_in = ST_SV_OUTER;
            end else begin
               cmd = CMD_RK_RDI;
               state_in = ST_RK_KEY;
            end
         end
         ST_RK_KEY: begin
            cmd = CMD_RK_KEY;
            state_in = ST_RK_RDJ;
         end
         ST_RK_RDJ: begin
            if (status.j_end) begin
               cmd = CMD_RK_PUT;
               state_in = ST_RK_RDI;
            end else begin
               cmd = CMD_RK_RDJ;
               state_in = ST_RK_CMP;
            end
         end
         ST_RK_CMP: begin
            cmd = CMD_RK_CMP;
            state_in = ST_RK_RDJ;
         end
         ST_SV_OUTER: begin
            if (status.outer_end) begin
               state_in = ST_DONE;
            end else begin
               cmd = CMD_SV_OUTER;
               state_in = ST_SV_CLR;
            end
         end
         ST_SV_CLR: begin
            cmd = CMD_SV_CLR;
            if (status.clr_last) state_in = ST_SV_ORD;
         end
         ST_SV_ORD: begin
            if (status.jc_end) begin
               cmd = CMD_SV_NEXTI;
               state_in = ST_SV_OUTER;
            end else begin
               cmd = CMD_SV_ORD;
               state_in = ST_SV_EDGE;
            end
         end
         ST_SV_EDGE: begin
            cmd = CMD_SV_EDGE;
            state_in = ST_SV_GOT;
         end
         ST_SV_GOT: begin
            cmd = CMD_SV_GOT;
            state_in = ST_SV_FRD;
         end
         ST_SV_FRD: begin
            cmd = CMD_SV_FRD;
            state_in = ST_SV_FCHK;
         end
         ST_SV_FCHK: begin
            cmd = CMD_SV_FCHK;
            state_in = (status.root && status.phase) ? ST_SV_SZA : ST_SV_FRD;
         end
         ST_SV_SZA: begin
            if (status.same_root) begin
               cmd = CMD_SV_NEXTJ;
               state_in = ST_SV_ORD;
            end else begin
               cmd = CMD_SV_SZA;
               state_in = ST_SV_SZB;
            end
         end
         ST_SV_SZB: begin
            cmd = CMD_SV_SZB;
            state_in = ST_SV_MERGE;
         end
         ST_SV_MERGE: begin
            cmd = CMD_SV_MERGE;
            state_in = status.last_merge ? ST_SV_OUTER : ST_SV_ORD;
         end
         ST_DONE: begin
            cmd = CMD_FINISH;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign busy       = (state_ff != ST_IDLE);

endmodule
